FILE: sv/twcs_pkg.sv
// Shared types and constants for the textured wall column sampler.
// No dependencies; every other file but twcs_ram imports this package.
`default_nettype none
package twcs_pkg;

  localparam int TEX_SIZE_DEF = 64;
  localparam int TEX_COUNT    = 4;
  localparam logic [23:0] HALF_MASK = 24'd8355711;
  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // One classified command waiting for the back end.
  typedef struct packed {
    cmd_t        kind;
    logic [1:0]  sel;
    logic [11:0] idx;
    logic [23:0] texel;
    logic        side;
    logic [1:0]  tex;
    logic        mirror;
    logic [15:0] pmid;
    logic [15:0] plow;
    logic [15:0] lh;
  } entry_t;

endpackage
`default_nettype wire

FILE: sv/twcs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module twcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/twcs_front.sv
// Front end: accepts commands, picks texture and mirroring, forms the ray
// product. Depends on twcs_pkg.
`default_nettype none
module twcs_front #(
  parameter int TEX_SIZE = twcs_pkg::TEX_SIZE_DEF
) (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [1:0]         tex_select,
  input  wire logic [11:0]        index,
  input  wire logic [23:0]        texel_value,
  input  wire logic               side,
  input  wire logic signed [19:0] ray_dir_x,
  input  wire logic signed [19:0] ray_dir_y,
  input  wire logic [27:0]        pos_x,
  input  wire logic [27:0]        pos_y,
  input  wire logic [27:0]        perp_dist,
  input  wire logic [15:0]        line_height,
  input  wire logic               full,
  output logic                    push,
  output twcs_pkg::entry_t        entry
);
  import twcs_pkg::*;

  logic               accept;
  logic               rdx_pos;
  logic               rdy_pos;
  logic signed [19:0] ray;
  logic signed [48:0] prod;
  logic               in_range;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign rdx_pos  = !ray_dir_x[19] && (ray_dir_x != 20'sd0);
  assign rdy_pos  = !ray_dir_y[19] && (ray_dir_y != 20'sd0);
  assign ray      = side ? ray_dir_x : ray_dir_y;
  assign prod     = $signed({1'b0, perp_dist}) * ray;
  assign in_range = 32'(index) < 32'(TEX_SIZE * TEX_SIZE);

  always_comb begin
    entry.kind   = cmd_t'(command);
    entry.sel    = tex_select;
    entry.idx    = index;
    entry.texel  = texel_value;
    entry.side   = side;
    entry.tex    = side ? (ray_dir_y[19] ? 2'd2 : 2'd3) : (rdx_pos ? 2'd1 : 2'd0);
    entry.mirror = side ? rdy_pos : rdx_pos;
    entry.pmid   = prod[31:16];
    entry.plow   = side ? pos_x[15:0] : pos_y[15:0];
    entry.lh     = (line_height == 16'd0) ? 16'd1 : line_height;
    case (cmd_t'(command))
      CMD_LOAD:  push = accept && in_range;
      CMD_START: push = accept;
      CMD_DRAW:  push = accept;
      default:   push = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/twcs_fifo.sv
// Two-entry queue of classified commands between front and back end.
// Depends on twcs_pkg.
`default_nettype none
module twcs_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  twcs_pkg::entry_t      wr_entry,
  output logic                  full,
  output logic                  not_empty,
  input  wire logic             pop,
  output twcs_pkg::entry_t      rd_entry
);
  import twcs_pkg::*;

  entry_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign rd_entry  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: sv/twcs_back.sv
// Back end: texture writes, column setup, serial texture row division,
// texel fetch and the output register. Depends on twcs_pkg and twcs_ram.
`default_nettype none
module twcs_back #(
  parameter int TEX_SIZE = twcs_pkg::TEX_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        not_empty,
  input  twcs_pkg::entry_t rd_entry,
  output logic             pop,
  input  wire logic [12:0] screen_width,
  input  wire logic [12:0] screen_height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      pixel_address,
  output logic [23:0]      pixel_color
);
  import twcs_pkg::*;

  localparam int QB    = $clog2(TEX_SIZE);
  localparam int DEPTH = TEX_COUNT * TEX_SIZE * TEX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NUMW  = 21 + QB;
  localparam int CW    = $clog2(QB + 1);
  localparam int FW    = 17 + QB;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_READ, S_OUT} state_t;

  state_t                 state;
  logic [1:0]             cur_tex;
  logic [QB-1:0]          cur_tcol;
  logic [11:0]            cur_column;
  logic                   cur_side;
  logic [15:0]            cur_lh;
  logic signed [NUMW-1:0] num;
  logic [16:0]            den;
  logic [NUMW-1:0]        rem;
  logic [NUMW-1:0]        dsh;
  logic [QB-1:0]          quo;
  logic [CW-1:0]          cnt;
  logic [QB-1:0]          row;
  logic [23:0]            addr_r;

  logic signed [19:0]     s_val;
  logic [15:0]            frac;
  logic [FW-1:0]          fprod;
  logic [QB-1:0]          tcol;
  logic [NUMW-1:0]        den_ts;
  logic                   can_load;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [23:0]            rdata;

  assign pop      = (state == S_IDLE) && not_empty;
  assign s_val    = $signed({7'd0, rd_entry.idx, 1'b0}) - $signed({7'd0, screen_height})
                    + $signed({4'd0, cur_lh});
  assign frac     = rd_entry.plow + rd_entry.pmid;
  assign fprod    = FW'(frac) * FW'(TEX_SIZE);
  assign tcol     = rd_entry.mirror ? QB'(TEX_SIZE - 1) - fprod[16 +: QB] : fprod[16 +: QB];
  assign den_ts   = NUMW'(den) * NUMW'(TEX_SIZE);
  assign can_load = !out_valid || !out_stall;
  assign we       = pop && (rd_entry.kind == CMD_LOAD);
  assign waddr    = AW'(rd_entry.sel) * AW'(TEX_SIZE * TEX_SIZE) + AW'(rd_entry.idx);
  assign re       = state == S_READ;
  assign raddr    = AW'(cur_tex) * AW'(TEX_SIZE * TEX_SIZE) + AW'(row) * AW'(TEX_SIZE)
                    + AW'(cur_tcol);

  twcs_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(rd_entry.texel),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_tex    <= 2'd0;
      cur_tcol   <= '0;
      cur_column <= 12'd0;
      cur_side   <= 1'b0;
      cur_lh     <= 16'd1;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            case (rd_entry.kind)
              CMD_START: begin
                cur_tex    <= rd_entry.tex;
                cur_tcol   <= tcol;
                cur_column <= rd_entry.idx;
                cur_side   <= rd_entry.side;
                cur_lh     <= rd_entry.lh;
              end
              CMD_DRAW: begin
                num    <= NUMW'(s_val) * $signed(NUMW'(TEX_SIZE)) - NUMW'(2);
                den    <= {cur_lh, 1'b0};
                addr_r <= 24'(rd_entry.idx) * 24'(screen_width) + 24'(cur_column);
                state  <= S_CHECK;
              end
              default: begin
              end
            endcase
          end
        end
        S_CHECK: begin
          if (num[NUMW-1]) begin
            row   <= '0;
            state <= S_READ;
          end else if (NUMW'(num) >= den_ts) begin
            row   <= QB'(TEX_SIZE - 1);
            state <= S_READ;
          end else begin
            rem   <= NUMW'(num);
            dsh   <= NUMW'(den) << (QB - 1);
            quo   <= '0;
            cnt   <= CW'(QB);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[QB-2:0], 1'b1};
          end else begin
            quo <= {quo[QB-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (can_load) begin
            pixel_address <= addr_r;
            pixel_color   <= cur_side ? ((rdata >> 1) & HALF_MASK) : rdata;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && cnt == CW'(1)) begin
        row <= (rem >= dsh) ? {quo[QB-2:0], 1'b1} : {quo[QB-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/textured_wall_column_sampler.sv
// Textured wall column sampler: a front end that classifies commands, a
// two-entry command queue, and a back end with the texture memory and a
// serial divider. Loads and column starts are handled in the idle state;
// a draw goes through a check state, the bit-per-cycle texture row
// division, a RAM read state and an output state. A draw whose row lands
// outside the texture skips the division. The queue lets commands be
// accepted while the back end works, and the output register
// lets the back end move on while a result transaction waits. The four
// textures are not cleared: a texel must be loaded before it is drawn.
// Depends on twcs_pkg, twcs_front, twcs_fifo, twcs_back and twcs_ram.
`default_nettype none
module textured_wall_column_sampler #(
  parameter int TEX_SIZE = twcs_pkg::TEX_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration port. Address bit 2 selects screen height over width.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Command channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [1:0]         tex_select,
  input  wire logic [11:0]        index,
  input  wire logic [23:0]        texel_value,
  input  wire logic               side,
  input  wire logic signed [19:0] ray_dir_x,
  input  wire logic signed [19:0] ray_dir_y,
  input  wire logic [27:0]        pos_x,
  input  wire logic [27:0]        pos_y,
  input  wire logic [27:0]        perp_dist,
  input  wire logic [15:0]        line_height,
  // Pixel channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [23:0]             pixel_address,
  output logic [23:0]             pixel_color
);
  import twcs_pkg::*;

  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic        push;
  logic        full;
  logic        not_empty;
  logic        pop;
  entry_t      wr_entry;
  entry_t      rd_entry;

  // Register writes complete in the access phase; the port never waits.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {19'd0, screen_height} : {19'd0, screen_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        screen_height <= pwdata[12:0];
      end else begin
        screen_width <= pwdata[12:0];
      end
    end
  end

  // The front end drops unknown commands and out-of-range loads.
  twcs_front #(.TEX_SIZE(TEX_SIZE)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .tex_select (tex_select),
    .index      (index),
    .texel_value(texel_value),
    .side       (side),
    .ray_dir_x  (ray_dir_x),
    .ray_dir_y  (ray_dir_y),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .perp_dist  (perp_dist),
    .line_height(line_height),
    .full       (full),
    .push       (push),
    .entry      (wr_entry)
  );

  twcs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .not_empty(not_empty),
    .pop      (pop),
    .rd_entry (rd_entry)
  );

  twcs_back #(.TEX_SIZE(TEX_SIZE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .rd_entry     (rd_entry),
    .pop          (pop),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color)
  );

endmodule
`default_nettype wire

FILE: bench/textured_wall_column_sampler_tb.sv
// Self-checking testbench for the textured wall column sampler.
// It needs twcs_pkg and the RTL of textured_wall_column_sampler.
// It loads any texel a draw is about to read first, runs a directed table and then
// random phases under several screen sizes.
`default_nettype none
module textured_wall_column_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twcs_pkg::*;

  localparam int TSZ = 64;
  localparam int TEXELS = TSZ * TSZ;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1700;

  // One command transaction on the input channel.
  typedef struct {
    cmd_t        cmd;
    logic [1:0]  sel;
    logic [11:0] idx;
    logic [23:0] texel;
    logic        sd;
    logic signed [19:0] rdx;
    logic signed [19:0] rdy;
    logic [27:0] px;
    logic [27:0] py;
    logic [27:0] wall_dist;
    logic [15:0] lh;
  } cmd_item_t;

  typedef struct {
    logic [23:0] addr;
    logic [23:0] color;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [1:0] tex_select = '0;
  logic [11:0] index = '0;
  logic [23:0] texel_value = '0;
  logic side = 1'b0;
  logic signed [19:0] ray_dir_x = '0;
  logic signed [19:0] ray_dir_y = '0;
  logic [27:0] pos_x = '0, pos_y = '0, perp_dist = '0;
  logic [15:0] line_height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] pixel_address, pixel_color;

  textured_wall_column_sampler uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .tex_select(tex_select),
    .index(index), .texel_value(texel_value), .side(side), .ray_dir_x(ray_dir_x),
    .ray_dir_y(ray_dir_y), .pos_x(pos_x), .pos_y(pos_y), .perp_dist(perp_dist),
    .line_height(line_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_address(pixel_address), .pixel_color(pixel_color)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: a private copy of the textures, the column context and the registers.
  logic [23:0] tex_mem [0:TEX_COUNT*TEXELS-1];
  bit          tex_written [0:TEX_COUNT*TEXELS-1];
  logic [1:0]  col_tex;
  logic [5:0]  col_tex_column;
  logic [11:0] col_screen_x;
  logic        col_side;
  logic [15:0] col_line_height;
  logic [12:0] scr_width, scr_height;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     unexpected = 0;
  int     items_sent = 0;
  bit     idling_on = 1'b1;   // Cleared for a stretch of the random part.
  bit     hold_go = 1'b0;     // Starts the long receiver hold-off.
  bit     holding = 1'b0;

  // Texel that a draw of the given screen row reads under the current column context.
  function automatic int draw_addr(logic [11:0] row);
    longint num, trow;
    num = (2 * longint'(row) - longint'(scr_height) + longint'(col_line_height))
          * TSZ - 2;
    if (num < 0) trow = 0;
    else begin
      trow = num / (2 * longint'(col_line_height));
      if (trow > TSZ - 1) trow = TSZ - 1;
    end
    return int'(col_tex) * TEXELS + int'(trow) * TSZ + int'(col_tex_column);
  endfunction

  // Apply one accepted transaction to the predictor and queue any pixel it produces.
  task automatic sample_pixel(input cmd_item_t it, input bit typed, input pixel_t typed_px);
    logic signed [63:0] prod;
    logic [15:0] frac;
    logic [5:0]  tcol;
    logic [23:0] color;
    pixel_t px;
    case (it.cmd)
      CMD_LOAD: begin
        tex_mem[it.sel * TEXELS + it.idx] = it.texel;
        tex_written[it.sel * TEXELS + it.idx] = 1'b1;
      end
      CMD_START: begin
        if (it.sd) col_tex = (it.rdy < 0) ? 2'd2 : 2'd3;
        else col_tex = (it.rdx > 0) ? 2'd1 : 2'd0;
        // Only bits 16..31 of the product reach the fraction, so the shift kind is moot.
        if (it.sd == 1'b0) begin
          prod = $signed({36'd0, it.wall_dist}) * it.rdy;
          frac = it.py[15:0] + prod[31:16];
        end else begin
          prod = $signed({36'd0, it.wall_dist}) * it.rdx;
          frac = it.px[15:0] + prod[31:16];
        end
        tcol = frac[15:10];
        // The face is seen from behind: mirror the texture column.
        if ((it.sd == 1'b0 && it.rdx > 0) || (it.sd == 1'b1 && it.rdy > 0))
          tcol = 6'(TSZ - 1) - tcol;
        col_tex_column = tcol;
        col_screen_x = it.idx;
        col_side = it.sd;
        col_line_height = (it.lh == 16'd0) ? 16'd1 : it.lh;
      end
      CMD_DRAW: begin
        color = tex_mem[draw_addr(it.idx)];
        if (col_side) color = (color >> 1) & HALF_MASK;
        px.addr = 24'(col_screen_x) + 24'(it.idx) * 24'(scr_width);
        px.color = color;
        pending_pixels.push_back(typed ? typed_px : px);
      end
      default: ;
    endcase
  endtask

  // Offer one transaction from the falling edge and wait until the block takes it.
  task automatic send_cmd(input cmd_item_t it, input bit typed = 1'b0,
                          input pixel_t typed_px = '{24'd0, 24'd0});
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command <= it.cmd;
    tex_select <= it.sel;
    index <= it.idx;
    texel_value <= it.texel;
    side <= it.sd;
    ray_dir_x <= it.rdx;
    ray_dir_y <= it.rdy;
    pos_x <= it.px;
    pos_y <= it.py;
    perp_dist <= it.wall_dist;
    line_height <= it.lh;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    sample_pixel(it, typed, typed_px);
  endtask

  function automatic cmd_item_t mk(cmd_t c, logic [1:0] s, logic [11:0] i, logic [23:0] t,
                                   logic sd, logic [19:0] rx, logic [19:0] ry,
                                   logic [27:0] x, logic [27:0] y, logic [27:0] d,
                                   logic [15:0] h);
    cmd_item_t it;
    it.cmd = c; it.sel = s; it.idx = i; it.texel = t; it.sd = sd;
    it.rdx = rx; it.rdy = ry; it.px = x; it.py = y; it.wall_dist = d; it.lh = h;
    return it;
  endfunction

  // A draw whose texel was never loaded is preceded by a load of that texel.
  task automatic send_item(input cmd_item_t it, input bit typed = 1'b0,
                           input pixel_t typed_px = '{24'd0, 24'd0});
    int a;
    if (it.cmd == CMD_DRAW) begin
      a = draw_addr(it.idx);
      if (!tex_written[a])
        send_cmd(mk(CMD_LOAD, 2'(a / TEXELS), 12'(a % TEXELS), 24'($urandom), 1'b0,
                    '0, '0, '0, '0, '0, '0));
    end
    send_cmd(it, typed, typed_px);
  endtask

  // Register write: setup cycle, then access cycle; the write lands at the access edge.
  task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == 3'd0) scr_width = value;
    else scr_height = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let all pixels arrive, then give loads and starts still in flight time to retire.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random command, mostly well-formed column sequences with noise mixed in.
  function automatic cmd_item_t rand_cmd();
    cmd_item_t it;
    int pick;
    pick = $urandom_range(99);
    it = mk(CMD_DRAW, 2'($urandom), 12'($urandom), 24'($urandom), 1'($urandom),
            20'($urandom), 20'($urandom), 28'($urandom), 28'($urandom), 28'($urandom),
            16'($urandom));
    if (pick < 15) it.cmd = CMD_LOAD;
    else if (pick < 30) it.cmd = CMD_START;
    else if (pick < 95) it.cmd = CMD_DRAW;
    else it.cmd = CMD_NONE;
    case ($urandom_range(3))
      0: it.wall_dist = 28'($urandom_range(0, 32'h3FFFF));
      1: it.wall_dist = 28'($urandom_range(0, 255));
      default: ;
    endcase
    if ($urandom_range(9) == 0) it.rdx = '0;
    if ($urandom_range(9) == 0) it.rdy = '0;
    case ($urandom_range(9))
      0: it.lh = 16'd0;
      1: it.lh = 16'hFFFF;
      2, 3, 4, 5: it.lh = 16'($urandom_range(1, 64));
      6, 7: it.lh = 16'($urandom_range(1, 2 * scr_height));
      default: ;
    endcase
    // Most draw rows fall on the screen so that the texture row lands inside the wall.
    if (it.cmd == CMD_DRAW && $urandom_range(3) != 0)
      it.idx = 12'($urandom_range(0, (scr_height > 4095) ? 4095 : scr_height));
    return it;
  endfunction

  // Receiver stall: random idling, or a long counted hold-off once.
  always @(negedge clk) begin
    out_stall <= holding || (idling_on && $urandom_range(99) < 17);
  end

  initial begin
    wait (hold_go);
    holding = 1'b1;
    repeat (400) @(negedge clk);
    holding = 1'b0;
  end

  // Pixel checker: compare every accepted pixel with the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected pixel addr=%h color=%h", pixel_address, pixel_color);
      end else begin
        want = pending_pixels.pop_front();
        if (want.addr !== pixel_address || want.color !== pixel_color) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("pixel mismatch: expected addr=%h color=%h, got addr=%h color=%h",
                     want.addr, want.color, pixel_address, pixel_color);
        end
      end
    end
  end

  // Directed table; rows with a typed pixel are checked against it, the rest against
  // the predictor.
  cmd_item_t dir_tbl[$];
  bit        dir_typed[$];
  pixel_t    dir_px[$];

  task automatic add_row(input cmd_item_t it, input bit typed = 1'b0,
                         input logic [23:0] a = '0, input logic [23:0] c = '0);
    pixel_t p;
    p.addr = a;
    p.color = c;
    dir_tbl.push_back(it);
    dir_typed.push_back(typed);
    dir_px.push_back(p);
  endtask

  initial begin
    logic [12:0] widths [4];
    logic [12:0] heights [4];
    int n;
    int base;
    col_tex = '0;
    col_tex_column = '0;
    col_screen_x = '0;
    col_side = 1'b0;
    col_line_height = 16'd1;
    scr_width = SCREEN_WIDTH_RST;
    scr_height = SCREEN_HEIGHT_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A draw before any start uses the reset column context.
    add_row(mk(CMD_DRAW, 2'd0, 12'd0, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Slot 0 texel 0 white, straight column 5: row 0 clamps to texture row 0.
    add_row(mk(CMD_LOAD, 2'd0, 12'd0, 24'hFFFFFF, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_START, 2'd3, 12'd5, '0, 1'b0, 20'sd0, 20'sd0, '0, '0, '0, 16'd1));
    add_row(mk(CMD_DRAW, 2'd0, 12'd0, '0, 1'b0, '0, '0, '0, '0, '0, '0),
            1'b1, 24'd5, 24'hFFFFFF);
    // Y-side face with negative ray y picks slot 2 and halves the colour.
    add_row(mk(CMD_LOAD, 2'd2, 12'd0, 24'hFFFFFF, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_START, 2'd0, 12'd0, '0, 1'b1, 20'sd0, -20'sd1, '0, '0, '0, 16'd0));
    add_row(mk(CMD_DRAW, 2'd0, 12'd0, '0, 1'b0, '0, '0, '0, '0, '0, '0),
            1'b1, 24'd0, 24'h7F7F7F);
    // Largest row index: clamps to the bottom texture row.
    add_row(mk(CMD_DRAW, 2'd0, 12'd4095, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Mirrored x-side with extreme ray and position values.
    add_row(mk(CMD_START, 2'd0, 12'd4095, 24'hFFFFFF, 1'b0, 20'sh7FFFF, 20'sh80000,
               28'hFFFFFFF, 28'hFFFFFFF, 28'hFFFFFFF, 16'hFFFF));
    add_row(mk(CMD_DRAW, 2'd0, 12'd240, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_DRAW, 2'd0, 12'd4095, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Mirrored y-side, slot 3, with a wall taller than the screen.
    add_row(mk(CMD_START, 2'd1, 12'd100, '0, 1'b1, 20'sh80000, 20'sh7FFFF,
               28'h0012345, 28'h0ABCDEF, 28'h0030000, 16'd1000));
    add_row(mk(CMD_DRAW, 2'd0, 12'd0, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_DRAW, 2'd0, 12'd239, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_DRAW, 2'd0, 12'd479, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Positive ray x on the x-side: slot 1, short wall around the centre.
    add_row(mk(CMD_START, 2'd0, 12'd639, '0, 1'b0, 20'sd65536, 20'sd32768,
               28'h0018000, 28'h0024000, 28'h0020000, 16'd64));
    add_row(mk(CMD_DRAW, 2'd0, 12'd208, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_DRAW, 2'd0, 12'd240, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    add_row(mk(CMD_DRAW, 2'd0, 12'd271, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // An unknown command is ignored and leaves the column context alone.
    add_row(mk(CMD_NONE, 2'd3, 12'hFFF, 24'hFFFFFF, 1'b1, 20'sh7FFFF, 20'sh7FFFF,
               28'hFFFFFFF, 28'hFFFFFFF, 28'hFFFFFFF, 16'hFFFF));
    add_row(mk(CMD_DRAW, 2'd0, 12'd250, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Load at the highest texel index of slot 3.
    add_row(mk(CMD_LOAD, 2'd3, 12'd4095, 24'h123456, 1'b0, '0, '0, '0, '0, '0, '0));
    for (int r = 0; r < dir_tbl.size(); r++)
      send_item(dir_tbl[r], dir_typed[r], dir_px[r]);
    wait_idle();

    // Random phases, each under its own screen size.
    widths = '{13'd1, 13'd4096, 13'd640, 13'($urandom_range(1, 4096))};
    heights = '{13'd1, 13'd4096, 13'd480, 13'($urandom_range(1, 4096))};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(3'd0, widths[ph]);
      write_reg(3'd4, heights[ph]);
      if (ph == 1) hold_go = 1'b1;
      n = 0;
      while (n < RANDOM_ITEMS / 4) begin
        // A stretch with no idling on either side.
        idling_on = !(ph == 2 && n >= 100 && n < 300);
        base = items_sent;
        send_item(rand_cmd());
        n += items_sent - base;
      end
      idling_on = 1'b1;
      wait_idle();
    end

    if (mismatches == 0 && unexpected == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
